// ----- design/abd_pkg.sv -----
package abd_pkg;

  localparam int MAX_CLASSES     = 7;
  localparam int NUM_SCORES      = 7;
  localparam int COORD_FRAC_BITS = 4;

  localparam int SCORE_W    = 16;
  localparam int CLASS_W    = 3;
  localparam int COORD_W    = 10 + COORD_FRAC_BITS;
  localparam int PAD_W      = 10;
  localparam int SIZE_W     = 13;
  localparam int SCALE_W    = 24;
  localparam int SCALE_FRAC = 16;
  localparam int OUT_W      = 12;
  localparam int OUT_MAX    = (1 << OUT_W) - 1;

  // corner with one extra fraction bit, signed
  localparam int DBL_W      = COORD_W + 3;
  localparam int PROD_SHIFT = COORD_FRAC_BITS + 1 + SCALE_FRAC;
  localparam int PROD_W     = DBL_W + SCALE_W + 1;
  localparam int CLAMP_W    = OUT_W + PROD_SHIFT;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLASS_COUNT     = 3'd0,
    REG_SCORE_THRESHOLD = 3'd1,
    REG_INVERSE_SCALE   = 3'd2,
    REG_PAD_LEFT        = 3'd3,
    REG_PAD_TOP         = 3'd4,
    REG_IMAGE_WIDTH     = 3'd5,
    REG_IMAGE_HEIGHT    = 3'd6
  } cfg_reg_t;

  localparam logic [CLASS_W-1:0] RST_CLASS_COUNT     = 3'd2;
  localparam logic [SCORE_W-1:0] RST_SCORE_THRESHOLD = 16'd16384;
  localparam logic [SCALE_W-1:0] RST_INVERSE_SCALE   = 24'd65536;
  localparam logic [PAD_W-1:0]   RST_PAD             = '0;
  localparam logic [SIZE_W-1:0]  RST_IMAGE_WIDTH     = 13'd640;
  localparam logic [SIZE_W-1:0]  RST_IMAGE_HEIGHT    = 13'd480;

  typedef struct packed {
    logic [CLASS_W-1:0] class_count;
    logic [SCORE_W-1:0] score_threshold;
    logic [SCALE_W-1:0] inverse_scale;
    logic [PAD_W-1:0]   pad_left;
    logic [PAD_W-1:0]   pad_top;
    logic [OUT_W-1:0]   lim_x;
    logic [OUT_W-1:0]   lim_y;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0]                center_x;
    logic [COORD_W-1:0]                center_y;
    logic [COORD_W-1:0]                box_width;
    logic [COORD_W-1:0]                box_height;
    logic [NUM_SCORES-1:0][SCORE_W-1:0] score;
    logic                              final_anchor;
  } in_item_t;

  typedef struct packed {
    logic                     pass;
    logic [CLASS_W-1:0]       class_id;
    logic [SCORE_W-1:0]       top_score;
    logic signed [DBL_W-1:0]  x1;
    logic signed [DBL_W-1:0]  y1;
    logic signed [DBL_W-1:0]  x2;
    logic signed [DBL_W-1:0]  y2;
    logic                     frame_end;
  } dec_t;

  typedef struct packed {
    logic                     pass;
    logic [CLASS_W-1:0]       class_id;
    logic [SCORE_W-1:0]       top_score;
    logic signed [PROD_W-1:0] x1;
    logic signed [PROD_W-1:0] y1;
    logic signed [PROD_W-1:0] x2;
    logic signed [PROD_W-1:0] y2;
    logic                     frame_end;
  } prod_t;

  typedef struct packed {
    logic               kept;
    logic [CLASS_W-1:0] class_id;
    logic [SCORE_W-1:0] top_score;
    logic [OUT_W-1:0]   left;
    logic [OUT_W-1:0]   top;
    logic [OUT_W-1:0]   right;
    logic [OUT_W-1:0]   bottom;
    logic               frame_end;
  } out_item_t;

endpackage

// ----- design/abd_if.sv -----
interface abd_in_if import abd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] center_x;
  logic [COORD_W-1:0] center_y;
  logic [COORD_W-1:0] box_width;
  logic [COORD_W-1:0] box_height;
  logic [SCORE_W-1:0] score_0;
  logic [SCORE_W-1:0] score_1;
  logic [SCORE_W-1:0] score_2;
  logic [SCORE_W-1:0] score_3;
  logic [SCORE_W-1:0] score_4;
  logic [SCORE_W-1:0] score_5;
  logic [SCORE_W-1:0] score_6;
  logic               final_anchor;

  modport source (
    output valid, center_x, center_y, box_width, box_height,
           score_0, score_1, score_2, score_3, score_4, score_5, score_6, final_anchor,
    input  ready
  );
  modport sink (
    input  valid, center_x, center_y, box_width, box_height,
           score_0, score_1, score_2, score_3, score_4, score_5, score_6, final_anchor,
    output ready
  );
endinterface

interface abd_out_if import abd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kept;
  logic [CLASS_W-1:0] class_id;
  logic [SCORE_W-1:0] top_score;
  logic [OUT_W-1:0]   left;
  logic [OUT_W-1:0]   top;
  logic [OUT_W-1:0]   right;
  logic [OUT_W-1:0]   bottom;
  logic               frame_end;

  modport source (
    output valid, kept, class_id, top_score, left, top, right, bottom, frame_end,
    input  ready
  );
  modport sink (
    input  valid, kept, class_id, top_score, left, top, right, bottom, frame_end,
    output ready
  );
endinterface

interface abd_cfg_if import abd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/abd_cfg_regs.sv -----
module abd_cfg_regs import abd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_valid,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  logic [CLASS_W-1:0] class_count_r;
  logic [SCORE_W-1:0] score_threshold_r;
  logic [SCALE_W-1:0] inverse_scale_r;
  logic [PAD_W-1:0]   pad_left_r;
  logic [PAD_W-1:0]   pad_top_r;
  logic [SIZE_W-1:0]  image_width_r;
  logic [SIZE_W-1:0]  image_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_count_r     <= RST_CLASS_COUNT;
      score_threshold_r <= RST_SCORE_THRESHOLD;
      inverse_scale_r   <= RST_INVERSE_SCALE;
      pad_left_r        <= RST_PAD;
      pad_top_r         <= RST_PAD;
      image_width_r     <= RST_IMAGE_WIDTH;
      image_height_r    <= RST_IMAGE_HEIGHT;
    end else if (wr_valid) begin
      case (wr_index)
        REG_CLASS_COUNT:     class_count_r     <= wr_data[CLASS_W-1:0];
        REG_SCORE_THRESHOLD: score_threshold_r <= wr_data[SCORE_W-1:0];
        REG_INVERSE_SCALE:   inverse_scale_r   <= wr_data[SCALE_W-1:0];
        REG_PAD_LEFT:        pad_left_r        <= wr_data[PAD_W-1:0];
        REG_PAD_TOP:         pad_top_r         <= wr_data[PAD_W-1:0];
        REG_IMAGE_WIDTH:     image_width_r     <= wr_data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT:    image_height_r    <= wr_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp limit is size-1, saturated to the output range
  function automatic logic [OUT_W-1:0] size_limit(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] dec;
    dec = size - SIZE_W'(1);
    if (size == '0) begin
      return '0;
    end else if (dec > SIZE_W'(OUT_MAX)) begin
      return OUT_W'(OUT_MAX);
    end else begin
      return dec[OUT_W-1:0];
    end
  endfunction

  always_comb begin
    cfg.class_count     = class_count_r;
    cfg.score_threshold = score_threshold_r;
    cfg.inverse_scale   = inverse_scale_r;
    cfg.pad_left        = pad_left_r;
    cfg.pad_top         = pad_top_r;
    cfg.lim_x           = size_limit(image_width_r);
    cfg.lim_y           = size_limit(image_height_r);
  end

endmodule

// ----- design/abd_decode.sv -----
module abd_decode import abd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     up_valid,
  output logic     up_ready,
  input  in_item_t up_item,
  output logic     dn_valid,
  input  logic     dn_ready,
  output dec_t     dn_item
);

  logic dn_valid_r;
  dec_t dn_item_r;
  dec_t dn_item_nxt;

  logic [CLASS_W-1:0]      n_used;
  logic [SCORE_W-1:0]      best;
  logic [CLASS_W-1:0]      cls;
  logic                    found;
  logic signed [DBL_W-1:0] cx2;
  logic signed [DBL_W-1:0] cy2;
  logic signed [DBL_W-1:0] bw;
  logic signed [DBL_W-1:0] bh;
  logic signed [DBL_W-1:0] px;
  logic signed [DBL_W-1:0] py;

  // strict greater-than scan, lowest index wins ties
  always_comb begin
    n_used = (cfg.class_count > CLASS_W'(MAX_CLASSES)) ? CLASS_W'(MAX_CLASSES)
                                                        : cfg.class_count;
    best  = '0;
    cls   = '0;
    found = 1'b0;
    for (int c = 0; c < MAX_CLASSES; c++) begin
      if ((CLASS_W'(c) < n_used) && (up_item.score[c] > best)) begin
        best  = up_item.score[c];
        cls   = CLASS_W'(c);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    cx2 = $signed(DBL_W'({up_item.center_x, 1'b0}));
    cy2 = $signed(DBL_W'({up_item.center_y, 1'b0}));
    bw  = $signed(DBL_W'(up_item.box_width));
    bh  = $signed(DBL_W'(up_item.box_height));
    px  = $signed(DBL_W'({cfg.pad_left, {(COORD_FRAC_BITS + 1){1'b0}}}));
    py  = $signed(DBL_W'({cfg.pad_top, {(COORD_FRAC_BITS + 1){1'b0}}}));

    dn_item_nxt.pass       = found && (best >= cfg.score_threshold);
    dn_item_nxt.class_id   = cls;
    dn_item_nxt.top_score  = best;
    dn_item_nxt.x1         = cx2 - bw - px;
    dn_item_nxt.y1         = cy2 - bh - py;
    dn_item_nxt.x2         = cx2 + bw - px;
    dn_item_nxt.y2         = cy2 + bh - py;
    dn_item_nxt.frame_end  = up_item.final_anchor;
  end

  assign up_ready = !dn_valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dn_valid_r <= 1'b0;
    end else if (up_ready) begin
      dn_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_item_r <= dn_item_nxt;
    end
  end

  assign dn_valid = dn_valid_r;
  assign dn_item  = dn_item_r;

endmodule

// ----- design/abd_scale.sv -----
module abd_scale import abd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  up_valid,
  output logic  up_ready,
  input  dec_t  up_item,
  output logic  dn_valid,
  input  logic  dn_ready,
  output prod_t dn_item
);

  logic  dn_valid_r;
  prod_t dn_item_r;
  prod_t dn_item_nxt;

  logic signed [PROD_W-1:0] scale_s;

  // four independent corner-by-scale multipliers
  always_comb begin
    scale_s = $signed(PROD_W'(cfg.inverse_scale));

    dn_item_nxt.pass       = up_item.pass;
    dn_item_nxt.class_id   = up_item.class_id;
    dn_item_nxt.top_score  = up_item.top_score;
    dn_item_nxt.x1         = PROD_W'(up_item.x1) * scale_s;
    dn_item_nxt.y1         = PROD_W'(up_item.y1) * scale_s;
    dn_item_nxt.x2         = PROD_W'(up_item.x2) * scale_s;
    dn_item_nxt.y2         = PROD_W'(up_item.y2) * scale_s;
    dn_item_nxt.frame_end  = up_item.frame_end;
  end

  assign up_ready = !dn_valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dn_valid_r <= 1'b0;
    end else if (up_ready) begin
      dn_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_item_r <= dn_item_nxt;
    end
  end

  assign dn_valid = dn_valid_r;
  assign dn_item  = dn_item_r;

endmodule

// ----- design/abd_clamp.sv -----
module abd_clamp import abd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      up_valid,
  output logic      up_ready,
  input  prod_t     up_item,
  output logic      dn_valid,
  input  logic      dn_ready,
  output out_item_t dn_item
);

  logic      dn_valid_r;
  out_item_t dn_item_r;
  out_item_t dn_item_nxt;

  logic [CLAMP_W-1:0] x1c;
  logic [CLAMP_W-1:0] y1c;
  logic [CLAMP_W-1:0] x2c;
  logic [CLAMP_W-1:0] y2c;
  logic               keep;

  // clamp to [0, limit] at full product precision
  function automatic logic [CLAMP_W-1:0] clamp_prod(input logic signed [PROD_W-1:0] p,
                                                     input logic [OUT_W-1:0] lim);
    logic [CLAMP_W-1:0] hi;
    hi = {lim, {PROD_SHIFT{1'b0}}};
    if (p[PROD_W-1]) begin
      return '0;
    end else if ($unsigned(p) > PROD_W'(hi)) begin
      return hi;
    end else begin
      return p[CLAMP_W-1:0];
    end
  endfunction

  always_comb begin
    x1c  = clamp_prod(up_item.x1, cfg.lim_x);
    y1c  = clamp_prod(up_item.y1, cfg.lim_y);
    x2c  = clamp_prod(up_item.x2, cfg.lim_x);
    y2c  = clamp_prod(up_item.y2, cfg.lim_y);
    keep = up_item.pass && (x2c > x1c) && (y2c > y1c);

    dn_item_nxt.kept       = keep;
    dn_item_nxt.class_id   = up_item.class_id;
    dn_item_nxt.top_score  = up_item.top_score;
    dn_item_nxt.left       = keep ? x1c[CLAMP_W-1 -: OUT_W] : '0;
    dn_item_nxt.top        = keep ? y1c[CLAMP_W-1 -: OUT_W] : '0;
    dn_item_nxt.right      = keep ? x2c[CLAMP_W-1 -: OUT_W] : '0;
    dn_item_nxt.bottom     = keep ? y2c[CLAMP_W-1 -: OUT_W] : '0;
    dn_item_nxt.frame_end  = up_item.frame_end;
  end

  assign up_ready = !dn_valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dn_valid_r <= 1'b0;
    end else if (up_ready) begin
      dn_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_item_r <= dn_item_nxt;
    end
  end

  assign dn_valid = dn_valid_r;
  assign dn_item  = dn_item_r;

endmodule

// ----- design/anchor_box_decode_filter.sv -----
// Anchor box decode and filter.
// in_ch takes one detector anchor per beat: center, size and seven class scores
// (class_count of them used) plus a frame-end mark. out_ch returns exactly one
// beat per anchor, in order: kept flag, best class and score, clamped corners
// in image pixels (zero when not kept) and the copied frame-end mark.
// cfg_ch writes one register per beat; it is always ready and should only be
// used while no anchor is in flight.
// Throughput: one anchor per cycle, sustained, while out_ch keeps ready high.
// The path is four registered stages: input register, argmax and corner
// arithmetic, the four corner multipliers, then clamp and extent check into
// the output register. Each stage holds its item while the next is full, so
// a stall on out_ch backs up to in_ch once all four are full and nothing is lost.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// defaults: two classes, threshold 0.25, unity scale, no padding, 640x480.
module anchor_box_decode_filter import abd_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  abd_in_if.sink    in_ch,
  abd_out_if.source out_ch,
  abd_cfg_if.sink   cfg_ch
);

  cfg_t      cfg;
  logic      in_valid_r;
  in_item_t  in_item_r;
  in_item_t  in_item_nxt;
  logic      dec_ready;
  logic      dec_valid;
  dec_t      dec_item;
  logic      scl_ready;
  logic      scl_valid;
  prod_t     scl_item;
  logic      clp_ready;
  out_item_t out_item;

  assign cfg_ch.ready = 1'b1;

  abd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  always_comb begin
    in_item_nxt.center_x     = in_ch.center_x;
    in_item_nxt.center_y     = in_ch.center_y;
    in_item_nxt.box_width    = in_ch.box_width;
    in_item_nxt.box_height   = in_ch.box_height;
    in_item_nxt.score[0]     = in_ch.score_0;
    in_item_nxt.score[1]     = in_ch.score_1;
    in_item_nxt.score[2]     = in_ch.score_2;
    in_item_nxt.score[3]     = in_ch.score_3;
    in_item_nxt.score[4]     = in_ch.score_4;
    in_item_nxt.score[5]     = in_ch.score_5;
    in_item_nxt.score[6]     = in_ch.score_6;
    in_item_nxt.final_anchor = in_ch.final_anchor;
  end

  assign in_ch.ready = !in_valid_r || dec_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r <= in_item_nxt;
    end
  end

  abd_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_valid_r),
    .up_ready (dec_ready),
    .up_item  (in_item_r),
    .dn_valid (dec_valid),
    .dn_ready (scl_ready),
    .dn_item  (dec_item)
  );

  abd_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (dec_valid),
    .up_ready (scl_ready),
    .up_item  (dec_item),
    .dn_valid (scl_valid),
    .dn_ready (clp_ready),
    .dn_item  (scl_item)
  );

  abd_clamp u_clamp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (scl_valid),
    .up_ready (clp_ready),
    .up_item  (scl_item),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_item  (out_item)
  );

  assign out_ch.kept       = out_item.kept;
  assign out_ch.class_id   = out_item.class_id;
  assign out_ch.top_score  = out_item.top_score;
  assign out_ch.left       = out_item.left;
  assign out_ch.top        = out_item.top;
  assign out_ch.right      = out_item.right;
  assign out_ch.bottom     = out_item.bottom;
  assign out_ch.frame_end  = out_item.frame_end;

`ifndef SYNTHESIS
  // a kept box never has inverted corners after truncation
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kept |-> (out_ch.right >= out_ch.left) &&
                                    (out_ch.bottom >= out_ch.top))
    else $error("kept box with inverted corners");

  // rejected anchors carry zero corners
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.kept |-> (out_ch.left == '0) && (out_ch.top == '0) &&
                                     (out_ch.right == '0) && (out_ch.bottom == '0))
    else $error("rejected anchor with nonzero corners");

  // a kept box passed the score threshold with a real class
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kept |-> (out_ch.top_score >= cfg.score_threshold) &&
                                    (out_ch.top_score != '0))
    else $error("kept box below score threshold");

  // the input side cannot stall while the pipeline has room at the front
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_ch.ready)
    else $error("input stalled with empty input register");
`endif

endmodule

// ----- dv/anchor_box_decode_filter_tb.sv -----
module anchor_box_decode_filter_tb import abd_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int MAX_SHOWN = 40;

  typedef struct {
    in_item_t  anchor;
    bit        typed;
    out_item_t box;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  abd_in_if  in_ch ();
  abd_out_if out_ch ();
  abd_cfg_if cfg_ch ();

  anchor_box_decode_filter uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copy seen by the predictor
  logic [CLASS_W-1:0] cur_class_count;
  logic [SCORE_W-1:0] cur_threshold;
  logic [SCALE_W-1:0] cur_inv_scale;
  logic [PAD_W-1:0]   cur_pad_left;
  logic [PAD_W-1:0]   cur_pad_top;
  logic [SIZE_W-1:0]  cur_img_w;
  logic [SIZE_W-1:0]  cur_img_h;

  out_item_t pending_boxes[$];
  dir_row_t  dir_rows[$];

  int err_count;
  int n_sent;
  int n_results;
  int n_kept;
  int n_frames;
  int n_settings;
  bit calm;
  bit burst;
  bit held;

  function automatic longint clamp_limit(logic [SIZE_W-1:0] size);
    longint lim;
    lim = (size == 0) ? 0 : longint'(size) - 1;
    if (lim > OUT_MAX) lim = OUT_MAX;
    return lim;
  endfunction

  // corner with F+1 fraction bits, scaled to F+17 and clamped to the image
  function automatic longint scale_clamp(longint dbl, longint lim);
    longint p;
    longint hi;
    p  = dbl * longint'(cur_inv_scale);
    hi = lim << PROD_SHIFT;
    if (p < 0) p = 0;
    if (p > hi) p = hi;
    return p;
  endfunction

  function automatic out_item_t decode_anchor(in_item_t a);
    out_item_t r;
    int n;
    int c;
    bit found;
    longint px, py, limx, limy, x1, y1, x2, y2;
    r = '0;
    found = 1'b0;
    n = (cur_class_count > MAX_CLASSES) ? MAX_CLASSES : cur_class_count;
    // strict compare, so the lowest index keeps a tie
    for (c = 0; c < n; c++) begin
      if (a.score[c] > r.top_score) begin
        r.top_score  = a.score[c];
        r.class_id   = c[CLASS_W-1:0];
        found        = 1'b1;
      end
    end
    r.frame_end = a.final_anchor;
    if (found && r.top_score >= cur_threshold) begin
      px   = longint'(cur_pad_left) << (COORD_FRAC_BITS + 1);
      py   = longint'(cur_pad_top) << (COORD_FRAC_BITS + 1);
      limx = clamp_limit(cur_img_w);
      limy = clamp_limit(cur_img_h);
      x1 = scale_clamp(2 * longint'(a.center_x) - longint'(a.box_width) - px, limx);
      y1 = scale_clamp(2 * longint'(a.center_y) - longint'(a.box_height) - py, limy);
      x2 = scale_clamp(2 * longint'(a.center_x) + longint'(a.box_width) - px, limx);
      y2 = scale_clamp(2 * longint'(a.center_y) + longint'(a.box_height) - py, limy);
      if (x2 > x1 && y2 > y1) begin
        r.kept   = 1'b1;
        r.left   = OUT_W'(x1 >> PROD_SHIFT);
        r.top    = OUT_W'(y1 >> PROD_SHIFT);
        r.right  = OUT_W'(x2 >> PROD_SHIFT);
        r.bottom = OUT_W'(y2 >> PROD_SHIFT);
      end
    end
    return r;
  endfunction

  function automatic in_item_t anchor(int cx, int cy, int bw, int bh,
                                      int s0, int s1, int s2, int s_hi, bit fin);
    in_item_t a;
    int k;
    a = '0;
    a.center_x   = COORD_W'(cx);
    a.center_y   = COORD_W'(cy);
    a.box_width  = COORD_W'(bw);
    a.box_height = COORD_W'(bh);
    a.score[0]   = SCORE_W'(s0);
    a.score[1]   = SCORE_W'(s1);
    a.score[2]   = SCORE_W'(s2);
    for (k = 3; k < NUM_SCORES; k++) a.score[k] = SCORE_W'(s_hi);
    a.final_anchor = fin;
    return a;
  endfunction

  function automatic out_item_t box_of(bit kp, int cls, int best, int l, int t,
                                       int rt, int bt, bit fe);
    out_item_t r;
    r.kept       = kp;
    r.class_id   = CLASS_W'(cls);
    r.top_score  = SCORE_W'(best);
    r.left       = OUT_W'(l);
    r.top        = OUT_W'(t);
    r.right      = OUT_W'(rt);
    r.bottom     = OUT_W'(bt);
    r.frame_end  = fe;
    return r;
  endfunction

  function automatic in_item_t random_anchor();
    in_item_t a;
    int shape;
    int win;
    int k;
    a = '0;
    shape = $urandom_range(0, 9);
    a.center_x = COORD_W'($urandom_range(0, 16383));
    a.center_y = COORD_W'($urandom_range(0, 16383));
    if (shape == 7) begin
      a.box_width  = COORD_W'($urandom);
      a.box_height = COORD_W'($urandom);
      for (k = 0; k < NUM_SCORES; k++) a.score[k] = SCORE_W'($urandom);
    end else begin
      // plausible or tiny boxes; low-noise scores with one high winner, all zero, or a tie
      a.box_width  = COORD_W'((shape == 9) ? $urandom_range(0, 3) : $urandom_range(0, 4000));
      a.box_height = COORD_W'((shape == 9) ? $urandom_range(0, 3) : $urandom_range(0, 4000));
      for (k = 0; k < NUM_SCORES; k++)
        a.score[k] = SCORE_W'((shape == 8) ? 0 : $urandom_range(0, 16'h3000));
      win = $urandom_range(0, NUM_SCORES - 1);
      if (shape != 8) a.score[win] = SCORE_W'($urandom_range(16'h2000, 16'hFFFF));
      if ($urandom_range(0, 5) == 0) a.score[$urandom_range(0, NUM_SCORES - 1)] = a.score[win];
    end
    a.final_anchor = ($urandom_range(0, 15) == 0);
    return a;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (err_count < MAX_SHOWN)
      $display("mismatch: %s got %0h want %0h at result %0d", what, got, want, n_results);
    err_count++;
  endtask

  task automatic take_result();
    out_item_t want;
    n_results++;
    if (pending_boxes.size() == 0) begin
      report_mismatch("result with nothing pending", out_ch.top_score, 0);
      return;
    end
    want = pending_boxes.pop_front();
    if (out_ch.kept != want.kept) report_mismatch("kept", out_ch.kept, want.kept);
    if (out_ch.class_id != want.class_id)
      report_mismatch("class_id", out_ch.class_id, want.class_id);
    if (out_ch.top_score != want.top_score)
      report_mismatch("top_score", out_ch.top_score, want.top_score);
    if (out_ch.left != want.left) report_mismatch("left", out_ch.left, want.left);
    if (out_ch.top != want.top) report_mismatch("top", out_ch.top, want.top);
    if (out_ch.right != want.right) report_mismatch("right", out_ch.right, want.right);
    if (out_ch.bottom != want.bottom) report_mismatch("bottom", out_ch.bottom, want.bottom);
    if (out_ch.frame_end != want.frame_end)
      report_mismatch("frame_end", out_ch.frame_end, want.frame_end);
    if (want.kept) n_kept++;
    if (want.frame_end) n_frames++;
  endtask

  task automatic send_anchor(in_item_t a, bit typed, out_item_t typed_box);
    out_item_t want;
    in_ch.valid        <= 1'b1;
    in_ch.center_x     <= a.center_x;
    in_ch.center_y     <= a.center_y;
    in_ch.box_width    <= a.box_width;
    in_ch.box_height   <= a.box_height;
    in_ch.score_0      <= a.score[0];
    in_ch.score_1      <= a.score[1];
    in_ch.score_2      <= a.score[2];
    in_ch.score_3      <= a.score[3];
    in_ch.score_4      <= a.score[4];
    in_ch.score_5      <= a.score[5];
    in_ch.score_6      <= a.score[6];
    in_ch.final_anchor <= a.final_anchor;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    want = typed ? typed_box : decode_anchor(a);
    pending_boxes = {pending_boxes, want};
    n_sent++;
  endtask

  task automatic idle_in();
    int gap;
    int r;
    gap = 0;
    if (!calm && !burst) begin
      r = $urandom_range(0, 99);
      if (r >= 95) gap = $urandom_range(15, 60);
      else if (r >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic stream_anchors(int count);
    repeat (count) begin
      send_anchor(random_anchor(), 1'b0, '0);
      idle_in();
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_CLASS_COUNT:     cur_class_count = data[CLASS_W-1:0];
      REG_SCORE_THRESHOLD: cur_threshold   = data[SCORE_W-1:0];
      REG_INVERSE_SCALE:   cur_inv_scale   = data[SCALE_W-1:0];
      REG_PAD_LEFT:        cur_pad_left    = data[PAD_W-1:0];
      REG_PAD_TOP:         cur_pad_top     = data[PAD_W-1:0];
      REG_IMAGE_WIDTH:     cur_img_w       = data[SIZE_W-1:0];
      REG_IMAGE_HEIGHT:    cur_img_h       = data[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int cc, int th, int sc, int pl, int pt, int w, int h);
    write_reg(REG_CLASS_COUNT, CFG_DATA_W'(cc));
    write_reg(REG_SCORE_THRESHOLD, CFG_DATA_W'(th));
    write_reg(REG_INVERSE_SCALE, CFG_DATA_W'(sc));
    write_reg(REG_PAD_LEFT, CFG_DATA_W'(pl));
    write_reg(REG_PAD_TOP, CFG_DATA_W'(pt));
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    cfg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  // result side: random stalls plus one long hold-off during the burst
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) take_result();
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (burst && !held) begin
        held = 1'b1;
        stall_left = 250;
        out_ch.ready <= 1'b0;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          out_ch.ready <= 1'b1;
        end else if (r < 96) begin
          stall_left = $urandom_range(0, 2);
          out_ch.ready <= 1'b0;
        end else begin
          stall_left = $urandom_range(15, 50);
          out_ch.ready <= 1'b0;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int w;
    int h;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.center_x     <= '0;
    in_ch.center_y     <= '0;
    in_ch.box_width    <= '0;
    in_ch.box_height   <= '0;
    in_ch.score_0      <= '0;
    in_ch.score_1      <= '0;
    in_ch.score_2      <= '0;
    in_ch.score_3      <= '0;
    in_ch.score_4      <= '0;
    in_ch.score_5      <= '0;
    in_ch.score_6      <= '0;
    in_ch.final_anchor <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= '0;
    cfg_ch.data        <= '0;
    calm  = 1'b0;
    burst = 1'b0;
    cur_class_count = RST_CLASS_COUNT;
    cur_threshold   = RST_SCORE_THRESHOLD;
    cur_inv_scale   = RST_INVERSE_SCALE;
    cur_pad_left    = RST_PAD;
    cur_pad_top     = RST_PAD;
    cur_img_w       = RST_IMAGE_WIDTH;
    cur_img_h       = RST_IMAGE_HEIGHT;

    // reset registers: two classes, threshold 0x4000, unity scale, 640x480
    dir_rows = {dir_rows, dir_row_t'{anchor(5120, 3840, 1600, 800, 0, 0, 0, 0, 0),
                                     1'b1, box_of(0, 0, 0, 0, 0, 0, 0, 0)}};
    dir_rows = {dir_rows, dir_row_t'{anchor(5120, 3840, 1600, 800, 'h4000, 0, 0, 0, 1),
                                     1'b1, box_of(1, 0, 'h4000, 270, 215, 370, 265, 1)}};
    dir_rows = {dir_rows, dir_row_t'{anchor(5120, 3840, 1600, 800, 'h3FFF, 'h1000, 0, 0, 0),
                                     1'b1, box_of(0, 0, 'h3FFF, 0, 0, 0, 0, 0)}};
    dir_rows = {dir_rows, dir_row_t'{anchor(5120, 3840, 1600, 800, 'h8000, 'h8000, 0, 0, 0),
                                     1'b1, box_of(1, 0, 'h8000, 270, 215, 370, 265, 0)}};
    dir_rows = {dir_rows, dir_row_t'{anchor(5120, 3840, 1600, 800, 'h5000, 'h9000, 0, 0, 0),
                                     1'b1, box_of(1, 1, 'h9000, 270, 215, 370, 265, 0)}};
    // scores past class_count are ignored
    dir_rows = {dir_rows, dir_row_t'{anchor(5120, 3840, 1600, 800, 'h5000, 0, 'hFFFF, 'hFFFF, 0),
                                     1'b1, box_of(1, 0, 'h5000, 270, 215, 370, 265, 0)}};
    dir_rows = {dir_rows, dir_row_t'{anchor(5120, 3840, 1600, 800, 0, 0, 'hFFFF, 'hFFFF, 0),
                                     1'b1, box_of(0, 0, 0, 0, 0, 0, 0, 0)}};
    // box lies below the image, both y corners clamp to the same row
    dir_rows = {dir_rows, dir_row_t'{anchor(16383, 16383, 16383, 16383,
                                            'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 1),
                                     1'b1, box_of(0, 0, 'hFFFF, 0, 0, 0, 0, 1)}};
    dir_rows = {dir_rows, dir_row_t'{anchor(0, 0, 16383, 16383,
                                            'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 0),
                                     1'b1, box_of(1, 0, 'hFFFF, 0, 0, 511, 479, 0)}};
    dir_rows = {dir_rows, dir_row_t'{anchor(5120, 3840, 0, 800, 'h8000, 0, 0, 0, 0),
                                     1'b1, box_of(0, 0, 'h8000, 0, 0, 0, 0, 0)}};
    dir_rows = {dir_rows, dir_row_t'{anchor(0, 0, 0, 0, 'h8000, 0, 0, 0, 0),
                                     1'b1, box_of(0, 0, 'h8000, 0, 0, 0, 0, 0)}};
    dir_rows = {dir_rows, dir_row_t'{anchor(5120, 3840, 1600, 800, 0, 'hFFFF, 0, 0, 1),
                                     1'b1, box_of(1, 1, 'hFFFF, 270, 215, 370, 265, 1)}};
    dir_rows = {dir_rows, dir_row_t'{anchor(5120, 3840, 1, 1, 'h8000, 0, 0, 0, 0),
                                     1'b0, '0}};
    dir_rows = {dir_rows, dir_row_t'{anchor(3000, 9000, 4000, 200, 'h4001, 'h4000, 0, 0, 0),
                                     1'b0, '0}};
    dir_rows = {dir_rows, dir_row_t'{anchor(16383, 0, 100, 16383, 'h7000, 'h7001, 0, 0, 1),
                                     1'b0, '0}};
    dir_rows = {dir_rows, dir_row_t'{anchor(10240, 7680, 16383, 1, 'hFFFF, 'hFFFE, 0, 0, 0),
                                     1'b0, '0}};
    dir_rows = {dir_rows, dir_row_t'{anchor(12345, 6789, 2222, 3333, 'h2000, 'h6000, 1, 1, 1),
                                     1'b0, '0}};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_anchor(dir_rows[i].anchor, dir_rows[i].typed, dir_rows[i].box);
      idle_in();
    end
    drain();

    // all classes, zero threshold, 4096x4096 image
    set_config(MAX_CLASSES, 0, 65536, 0, 0, 4096, 4096);
    stream_anchors(100);
    drain();

    // one class, top threshold, top scale and padding, one-pixel image
    set_config(1, 16'hFFFF, 24'hFFFFFF, 1023, 1023, 1, 1);
    stream_anchors(50);
    drain();

    // no classes in use, zero width, oversize height, then the unused index
    set_config(0, 0, 65536, 0, 0, 0, 8191);
    @(posedge clk);
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
    stream_anchors(40);
    drain();

    // oversize image with huge scale, corners saturate near 4095
    set_config(MAX_CLASSES, 16'h0100, 24'hFFFFFF, 0, 0, 8191, 8191);
    stream_anchors(40);
    drain();

    // zero scale drops every box
    set_config(3, 16'h0100, 0, 10, 10, 640, 480);
    stream_anchors(40);
    drain();

    // back-to-back beats while the result side holds off
    set_config(2, 16'h2000, 65536, 16, 12, 640, 480);
    burst = 1'b1;
    stream_anchors(200);
    burst = 1'b0;
    drain();

    for (int p = 0; p < 6; p++) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(4097, 8191) : $urandom_range(1, 4096);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(4097, 8191) : $urandom_range(1, 4096);
      set_config($urandom_range(1, MAX_CLASSES),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'hFFFF)
                                             : $urandom_range(0, 16'h5000),
                 $urandom_range(24'h8000, 24'h60000),
                 $urandom_range(0, 200), $urandom_range(0, 200), w, h);
      // first phase runs with no idling on either side
      calm = (p == 0);
      stream_anchors(p == 0 ? 100 : 95);
      drain();
      calm = 1'b0;
    end

    repeat (10) @(posedge clk);
    if (pending_boxes.size() != 0)
      report_mismatch("results never returned", pending_boxes.size(), 0);
    $display("covered %0d anchors over %0d register settings, %0d results, %0d kept",
             n_sent, n_settings, n_results, n_kept);
    $display("%0d frame ends seen, long result hold-off %s", n_frames,
             held ? "exercised" : "not reached");
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- anchor_box_decode_filter.f -----
design/abd_pkg.sv
design/abd_if.sv
design/abd_cfg_regs.sv
design/abd_decode.sv
design/abd_scale.sv
design/abd_clamp.sv
design/anchor_box_decode_filter.sv
dv/anchor_box_decode_filter_tb.sv
